// ===== design/tpg_pkg.sv =====
// Shared types, constants and pattern tables of the table pattern power generator.
// No dependencies; used by tpg_arith and table_pattern_power_generator_top.
package tpg_pkg;

	localparam int CNT_BITS_DEF = 12;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int PWR_W        = 16;
	localparam int TAG_W        = 16;
	localparam int IDX_W        = 4;
	localparam int OUT_DATA_W   = 40;
	localparam int OFS_W        = 12;
	localparam int SEL_W        = 3;
	localparam int CFG8_W       = 8;
	localparam int DIFF_W       = 17;
	localparam int PROD_W       = 25;
	localparam int QUO_W        = 18;

	localparam logic signed [PWR_W-1:0] LOW_RST   = 16'sd3840;
	localparam logic signed [PWR_W-1:0] HIGH_RST  = 16'sd6400;
	localparam logic [CFG8_W-1:0]       PULSE_RST = 8'd10;
	localparam logic [CFG8_W-1:0]       STEPS_RST = 8'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN = 3'd0,
		REG_LOW     = 3'd1,
		REG_HIGH    = 3'd2,
		REG_PULSE   = 3'd3,
		REG_STEPS   = 3'd4,
		REG_OFFSET  = 3'd5,
		REG_REVERSE = 3'd6
	} cfg_reg_t;

	typedef enum logic [SEL_W-1:0] {
		PAT_RECT    = 3'd0,
		PAT_STAIR4  = 3'd1,
		PAT_STAIR8  = 3'd2,
		PAT_SAW_UP  = 3'd3,
		PAT_SAW_DN  = 3'd4,
		PAT_RAMP    = 3'd5
	} pattern_t;

	// request to the serial multiply / divide unit
	typedef struct packed {
		logic                     start;
		logic                     div_en;
		logic [CFG8_W-1:0]        num;
		logic [CFG8_W-1:0]        den;
		logic signed [DIFF_W-1:0] diff;
	} tpg_req_t;

	function automatic logic [IDX_W-1:0] tbl_len(pattern_t p);
		logic [IDX_W-1:0] n;
		unique case (p)
			PAT_STAIR4: n = 4'd4;
			PAT_STAIR8: n = 4'd8;
			PAT_SAW_UP, PAT_SAW_DN: n = 4'd9;
			default: n = 4'd2;
		endcase
		return n;
	endfunction

	// table level in eighths of the span
	function automatic logic [IDX_W-1:0] tbl_level(pattern_t p, logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] lv;
		unique case (p)
			PAT_STAIR4: begin
				unique case (idx[1:0])
					2'd0: lv = 4'd4;
					2'd1: lv = 4'd8;
					2'd2: lv = 4'd4;
					default: lv = 4'd0;
				endcase
			end
			PAT_STAIR8: begin
				unique case (idx[2:0])
					3'd0: lv = 4'd4;
					3'd1: lv = 4'd6;
					3'd2: lv = 4'd8;
					3'd3: lv = 4'd6;
					3'd4: lv = 4'd4;
					3'd5: lv = 4'd2;
					3'd6: lv = 4'd0;
					default: lv = 4'd2;
				endcase
			end
			PAT_SAW_UP: lv = idx;
			PAT_SAW_DN: lv = 4'd8 - idx;
			default: lv = idx[0] ? 4'd8 : 4'd0;
		endcase
		return lv;
	endfunction

endpackage

// ===== design/tpg_arith.sv =====
// Serial arithmetic unit: diff * num by shift-add, one multiplier bit per cycle,
// then floor division by den (restoring, one quotient bit per cycle) or by 8.
// Depends on tpg_pkg.
module tpg_arith (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tpg_pkg::tpg_req_t                req,
	output logic                             done,
	output logic signed [tpg_pkg::QUO_W-1:0] quo
);
	import tpg_pkg::*;

	typedef enum logic [2:0] {A_IDLE, A_MUL, A_PREP, A_DIV, A_FIX} astate_t;

	astate_t                    state_q;
	logic [3:0]                 k_q;
	logic signed [PROD_W-1:0]   mcand_q;
	logic signed [PROD_W-1:0]   acc_q;
	logic [CFG8_W-1:0]          mplier_q;
	logic [CFG8_W-1:0]          den_q;
	logic                       div_en_q;
	logic                       neg_q;
	logic [CFG8_W-1:0]          rem_q;
	logic [15:0]                dvd_q;
	logic                       done_q;
	logic signed [QUO_W-1:0]    quo_q;

	logic [PROD_W-1:0]          mag;
	logic [CFG8_W:0]            trial;
	logic                       qbit;
	logic signed [QUO_W-1:0]    qpos;

	always_comb begin
		mag   = acc_q[PROD_W-1] ? (PROD_W'(0) - acc_q) : acc_q;
		trial = {rem_q, dvd_q[15]};
		qbit  = (trial >= {1'b0, den_q});
		qpos  = {2'b00, dvd_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			// one-cycle pulse as the result is registered
			done_q <= (state_q == A_FIX);
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						mcand_q  <= PROD_W'(req.diff);
						mplier_q <= req.num;
						den_q    <= req.den;
						div_en_q <= req.div_en;
						acc_q    <= '0;
						k_q      <= '0;
						state_q  <= A_MUL;
					end
				end
				A_MUL: begin
					if (mplier_q[0])
						acc_q <= acc_q + mcand_q;
					mcand_q  <= mcand_q <<< 1;
					mplier_q <= mplier_q >> 1;
					if (k_q == 4'd7) begin
						k_q     <= '0;
						state_q <= div_en_q ? A_PREP : A_FIX;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				A_PREP: begin
					// |product| < 2^24 and quotient < 2^16, so the top byte is below den
					neg_q   <= acc_q[PROD_W-1];
					rem_q   <= mag[23:16];
					dvd_q   <= mag[15:0];
					state_q <= A_DIV;
				end
				A_DIV: begin
					rem_q   <= qbit ? CFG8_W'(trial - {1'b0, den_q}) : trial[CFG8_W-1:0];
					dvd_q   <= {dvd_q[14:0], qbit};
					k_q     <= k_q + 4'd1;
					if (k_q == 4'd15)
						state_q <= A_FIX;
				end
				A_FIX: begin
					if (div_en_q) begin
						// floor toward minus infinity for a negative product
						if (neg_q)
							quo_q <= -qpos - QUO_W'(rem_q != '0);
						else
							quo_q <= qpos;
					end else begin
						quo_q <= acc_q[20:3];
					end
					k_q     <= '0;
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== design/table_pattern_power_generator_top.sv =====
// Table pattern transmit power generator, top level.
// Depends on tpg_pkg and tpg_arith.
//
// One result per input transfer: tx_power = low + floor((high - low) * level / den),
// saturated to Q8.8. In the table patterns an item passes the step index division, the
// shift-add multiplier and the sequencing states; in the continuous ramp a prep step and
// the restoring divider follow the multiplier. s_tready returns as the result is loaded
// into the output register, which ST_FIN waits for while that register is full and m_tready is low.
// A configuration write to a defined register reloads the phase counter through a serial
// modulo; s_tready stays low meanwhile. A finished result waits in the output register while
// the next item is taken in.
module table_pattern_power_generator_top #(
	parameter int COUNTER_BITS = tpg_pkg::CNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tpg_pkg::TAG_W-1:0]           s_tdata,  // [15:0] frame_tag
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tpg_pkg::OUT_DATA_W-1:0]      m_tdata,  // [15:0] tx_power, [31:16] tag_echo,
	                                                      // [35:32] step_index, [39:36] zero
	input  logic                                cfg_we,
	input  logic [tpg_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [tpg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import tpg_pkg::*;

	localparam int CW = (COUNTER_BITS > OFS_W) ? COUNTER_BITS : OFS_W;

	typedef enum logic [2:0] {ST_IDLE, ST_WRAP, ST_IDX, ST_LVL, ST_CALC, ST_FIN} state_t;

	// configuration
	logic [SEL_W-1:0]        pattern_q;
	logic signed [PWR_W-1:0] low_q;
	logic signed [PWR_W-1:0] high_q;
	logic [CFG8_W-1:0]       pulse_q;
	logic [CFG8_W-1:0]       steps_q;
	logic [OFS_W-1:0]        offset_q;
	logic                    reverse_q;

	// reload
	logic                    rl_busy_q;
	logic [3:0]              rl_k_q;
	logic [8:0]              rl_rem_q;

	state_t                  state_q;
	logic [COUNTER_BITS-1:0] cnt_q;
	logic [TAG_W-1:0]        tag_q;
	logic [IDX_W-1:0]        idx_q;
	logic [OFS_W-1:0]        irem_q;
	logic [1:0]              ik_q;

	logic                    m_tvalid_q;
	logic [PWR_W-1:0]        out_pwr_q;
	logic [TAG_W-1:0]        out_tag_q;
	logic [IDX_W-1:0]        out_idx_q;

	pattern_t                sel_n;
	logic                    ramp;
	logic [CFG8_W-1:0]       w_eff;
	logic [CFG8_W-1:0]       d_eff;
	logic [8:0]              period;
	logic [9:0]              rl_trial;
	logic [8:0]              rl_next;
	logic                    cfg_hit;
	logic [OFS_W-1:0]        tbl_lim;
	logic                    wrap;
	logic [COUNTER_BITS-1:0] cnt_w;
	logic [OFS_W-1:0]        dsh;
	logic                    out_free;
	logic signed [18:0]      sum;
	logic [PWR_W-1:0]        sat;

	tpg_req_t                req;
	logic                    ar_done;
	logic signed [QUO_W-1:0] ar_quo;

	always_comb begin
		sel_n    = (pattern_q > SEL_W'(PAT_RAMP)) ? PAT_RECT : pattern_t'(pattern_q);
		ramp     = (sel_n == PAT_RAMP);
		w_eff    = (pulse_q == '0) ? 8'd1 : pulse_q;
		d_eff    = (steps_q == '0) ? 8'd1 : steps_q;
		period   = ramp ? {1'b0, d_eff} : {w_eff, 1'b0};
		rl_trial = {rl_rem_q, offset_q[4'(OFS_W-1) - rl_k_q]};
		rl_next  = (rl_trial >= {1'b0, period}) ? 9'(rl_trial - {1'b0, period}) : rl_trial[8:0];
		cfg_hit  = cfg_we && (cfg_addr <= REG_REVERSE);
		tbl_lim  = OFS_W'(w_eff) * OFS_W'(tbl_len(sel_n));
		if (ramp)
			wrap = (CW'(cnt_q) > CW'(d_eff));
		else
			wrap = (CW'(cnt_q) >= CW'(tbl_lim));
		cnt_w    = wrap ? '0 : cnt_q;
		dsh      = OFS_W'(w_eff) << ik_q;
		out_free = !m_tvalid_q || m_tready;
		sum      = {{3{low_q[PWR_W-1]}}, low_q} + {ar_quo[QUO_W-1], ar_quo};
		if (sum > 19'sd32767)
			sat = 16'h7FFF;
		else if (sum < -19'sd32768)
			sat = 16'h8000;
		else
			sat = sum[PWR_W-1:0];
	end

	always_comb begin
		req.start  = 1'b0;
		req.div_en = 1'b0;
		req.num    = '0;
		req.den    = d_eff;
		req.diff   = {high_q[PWR_W-1], high_q} - {low_q[PWR_W-1], low_q};
		if (state_q == ST_WRAP && ramp) begin
			req.start  = 1'b1;
			req.div_en = 1'b1;
			req.num    = reverse_q ? (d_eff - cnt_w[CFG8_W-1:0]) : cnt_w[CFG8_W-1:0];
		end else if (state_q == ST_LVL) begin
			req.start = 1'b1;
			req.num   = CFG8_W'(tbl_level(sel_n, idx_q));
		end
	end

	tpg_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.done   (ar_done),
		.quo    (ar_quo)
	);

	assign s_tready = (state_q == ST_IDLE) && !rl_busy_q && !cfg_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q  <= SEL_W'(PAT_RECT);
			low_q      <= LOW_RST;
			high_q     <= HIGH_RST;
			pulse_q    <= PULSE_RST;
			steps_q    <= STEPS_RST;
			offset_q   <= '0;
			reverse_q  <= 1'b0;
			rl_busy_q  <= 1'b0;
			rl_k_q     <= '0;
			rl_rem_q   <= '0;
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// ST_FIN reloads the output register itself
			if (m_tvalid_q && m_tready && state_q != ST_FIN)
				m_tvalid_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_addr))
					REG_PATTERN: pattern_q <= cfg_wdata[SEL_W-1:0];
					REG_LOW:     low_q     <= cfg_wdata;
					REG_HIGH:    high_q    <= cfg_wdata;
					REG_PULSE:   pulse_q   <= cfg_wdata[CFG8_W-1:0];
					REG_STEPS:   steps_q   <= cfg_wdata[CFG8_W-1:0];
					REG_OFFSET:  offset_q  <= cfg_wdata[OFS_W-1:0];
					REG_REVERSE: reverse_q <= cfg_wdata[0];
					default: ;
				endcase
			end

			// start_offset mod period, one offset bit per cycle, MSB first
			if (cfg_hit) begin
				rl_busy_q <= 1'b1;
				rl_k_q    <= '0;
				rl_rem_q  <= '0;
			end else if (rl_busy_q) begin
				rl_rem_q <= rl_next;
				rl_k_q   <= rl_k_q + 4'd1;
				if (rl_k_q == 4'(OFS_W-1)) begin
					cnt_q     <= COUNTER_BITS'(rl_next);
					rl_busy_q <= 1'b0;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						tag_q   <= s_tdata;
						cnt_q   <= cnt_q + COUNTER_BITS'(1);
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					cnt_q  <= cnt_w;
					idx_q  <= '0;
					irem_q <= OFS_W'(cnt_w);
					ik_q   <= 2'd3;
					state_q <= ramp ? ST_CALC : ST_IDX;
				end
				ST_IDX: begin
					// step = counter / pulse_width, quotient below 16
					if (irem_q >= dsh) begin
						irem_q       <= irem_q - dsh;
						idx_q[ik_q]  <= 1'b1;
					end
					ik_q <= ik_q - 2'd1;
					if (ik_q == 2'd0)
						state_q <= ST_LVL;
				end
				ST_LVL: state_q <= ST_CALC;
				ST_CALC: begin
					if (ar_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_pwr_q  <= sat;
						out_tag_q  <= tag_q;
						out_idx_q  <= idx_q;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, out_idx_q, out_tag_q, out_pwr_q};

	// step index never leaves the longest table
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (out_idx_q <= 4'd8))
		else $error("step index out of range");

	a_ramp_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && ramp) |-> (out_idx_q == '0))
		else $error("nonzero step index in ramp mode");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !rl_busy_q && !ramp) |-> (CW'(cnt_q) < CW'(tbl_lim)))
		else $error("phase counter beyond table period");

	a_done_calc: assert property (@(posedge clk) disable iff (!arst_n)
		ar_done |-> (state_q == ST_CALC))
		else $error("arithmetic result outside calc state");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for table_pattern_power_generator_top: a directed table, then random config phases
// with random transfer gaps and output stalls, results checked against a local phase model or pinned values.
// Depends on tpg_pkg and the design sources.
module tb;
	import tpg_pkg::*;

	localparam int CNT_BITS    = CNT_BITS_DEF;
	localparam int CNT_MASK    = (1 << CNT_BITS) - 1;
	localparam int N_PHASES    = 25;
	localparam int PHASE_ITEMS = 65;
	localparam int HOLD_CYCLES = 300;
	localparam int WDOG_LIMIT  = 3000;
	localparam int TAIL_CYCLES = 48;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam logic [SEL_W-1:0]     PAT_SPARE = 3'd7;

	typedef struct packed {
		logic signed [PWR_W-1:0] power;
		logic [TAG_W-1:0]        tag;
		logic [IDX_W-1:0]        step;
	} tx_result_t;

	typedef struct packed {
		logic                    is_cfg;
		logic [CFG_IDX_W-1:0]    addr;
		logic [CFG_DATA_W-1:0]   value;
		logic                    pinned;
		logic signed [PWR_W-1:0] power;
		logic [IDX_W-1:0]        step;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [TAG_W-1:0]      s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tx_result_t power_q [$];
	int         errors = 0;
	int         quiet = 0;
	bit         idle_on = 1'b1;
	bit         hold_now = 1'b0;
	bit         pin_on = 1'b0;
	logic signed [PWR_W-1:0] pin_power;
	logic [IDX_W-1:0]        pin_step;

	// local copy of the generator state
	logic [SEL_W-1:0]        m_sel;
	logic signed [PWR_W-1:0] m_low;
	logic signed [PWR_W-1:0] m_high;
	logic [CFG8_W-1:0]       m_width;
	logic [CFG8_W-1:0]       m_steps;
	logic [OFS_W-1:0]        m_offset;
	logic                    m_rev;
	int                      m_phase;

	table_pattern_power_generator_top #(.COUNTER_BITS(CNT_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// codes 6 and 7 fall back to rectangular
	function automatic logic [SEL_W-1:0] active_pattern();
		return (m_sel > PAT_RAMP) ? PAT_RECT : m_sel;
	endfunction

	function automatic int eff_width();
		return (m_width == 0) ? 1 : int'(m_width);
	endfunction

	function automatic int eff_steps();
		return (m_steps == 0) ? 1 : int'(m_steps);
	endfunction

	function automatic void reload_phase();
		int period;
		period = (active_pattern() == PAT_RAMP) ? eff_steps() : 2 * eff_width();
		m_phase = (int'(m_offset) % period) & CNT_MASK;
	endfunction

	function automatic int table_len(logic [SEL_W-1:0] p);
		case (p)
			PAT_STAIR4: return 4;
			PAT_STAIR8: return 8;
			PAT_SAW_UP, PAT_SAW_DN: return 9;
			default: return 2;
		endcase
	endfunction

	// levels in eighths of the low..high span
	function automatic int level_of(logic [SEL_W-1:0] p, int idx);
		case (p)
			PAT_STAIR4: return (idx == 1) ? 8 : (idx == 3) ? 0 : 4;
			PAT_STAIR8: begin
				case (idx)
					0, 4: return 4;
					1, 3: return 6;
					2: return 8;
					6: return 0;
					default: return 2;
				endcase
			end
			PAT_SAW_UP: return idx;
			PAT_SAW_DN: return 8 - idx;
			default: return (idx == 1) ? 8 : 0;
		endcase
	endfunction

	function automatic logic [PWR_W-1:0] span_power(longint num, longint den);
		longint prod;
		longint q;
		longint v;
		prod = (longint'(m_high) - longint'(m_low)) * num;
		q = prod / den;
		if (prod % den != 0 && prod < 0) q = q - 1;
		v = longint'(m_low) + q;
		if (v > 32767) v = 32767;
		else if (v < -32768) v = -32768;
		return v[PWR_W-1:0];
	endfunction

	function automatic tx_result_t predict_power(logic [TAG_W-1:0] tag);
		tx_result_t r;
		logic [SEL_W-1:0] p;
		int d;
		int n;
		int w;
		int len;
		int idx;
		p = active_pattern();
		m_phase = (m_phase + 1) & CNT_MASK;
		r.tag = tag;
		r.step = '0;
		if (p == PAT_RAMP) begin
			d = eff_steps();
			if (m_phase > d) m_phase = 0;
			n = m_rev ? d - m_phase : m_phase;
			r.power = span_power(longint'(n), longint'(d));
		end else begin
			len = table_len(p);
			w = eff_width();
			if (m_phase >= w * len) m_phase = 0;
			idx = m_phase / w;
			if (idx >= len) idx = len - 1;
			r.power = span_power(longint'(level_of(p, idx)), longint'(8));
			r.step = IDX_W'(idx);
		end
		return r;
	endfunction

	function automatic void apply_cfg(logic [CFG_IDX_W-1:0] a, logic [CFG_DATA_W-1:0] v);
		case (a)
			REG_PATTERN: m_sel = v[SEL_W-1:0];
			REG_LOW:     m_low = v;
			REG_HIGH:    m_high = v;
			REG_PULSE:   m_width = v[CFG8_W-1:0];
			REG_STEPS:   m_steps = v[CFG8_W-1:0];
			REG_OFFSET:  m_offset = v[OFS_W-1:0];
			REG_REVERSE: m_rev = v[0];
			default: return;
		endcase
		reload_phase();
	endfunction

	function automatic void reset_model();
		m_sel = PAT_RECT;
		m_low = LOW_RST;
		m_high = HIGH_RST;
		m_width = PULSE_RST;
		m_steps = STEPS_RST;
		m_offset = '0;
		m_rev = 1'b0;
		reload_phase();
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] seen);
		if (seen !== want) begin
			$display("%0t %s mismatch: expected %h, got %h", $time, name, want, seen);
			errors++;
		end
	endfunction

	// config writes, input transfers and results, all sampled at the rising edge
	always @(posedge clk) begin : monitor
		tx_result_t want;
		tx_result_t seen;
		if (arst_n) begin
			if (cfg_we) apply_cfg(cfg_addr, cfg_wdata);
			if (s_tvalid && s_tready) begin
				want = predict_power(s_tdata);
				if (pin_on) begin
					want.power = pin_power;
					want.step = pin_step;
					pin_on = 1'b0;
				end
				power_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				seen.power = m_tdata[PWR_W-1:0];
				seen.tag = m_tdata[PWR_W+TAG_W-1:PWR_W];
				seen.step = m_tdata[PWR_W+TAG_W+IDX_W-1:PWR_W+TAG_W];
				if (power_q.size() == 0) begin
					$display("%0t unexpected result: expected none, got %h", $time, m_tdata);
					errors++;
				end else begin
					want = power_q.pop_front();
					check_field("tx_power", want.power, seen.power);
					check_field("tag_echo", want.tag, seen.tag);
					check_field("step_index", 16'(want.step), 16'(seen.step));
				end
			end
		end
	end

	// cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet == WDOG_LIMIT) begin
			$display("[table_pattern_power_generator_top] ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// output side: ready runs, random stalls, one long hold-off on request
	initial begin : sink
		int run;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_now) begin
				hold_now = 1'b0;
				m_tready <= 1'b0;
				run = HOLD_CYCLES;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				run = $urandom_range(1, 17);
			end else begin
				m_tready <= 1'b1;
				run = $urandom_range(1, 40);
			end
			repeat (run - 1) @(negedge clk);
		end
	end

	function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] a, logic [CFG_DATA_W-1:0] v);
		dir_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.addr = a;
		r.value = v;
		return r;
	endfunction

	function automatic dir_row_t item_row(logic [TAG_W-1:0] t);
		dir_row_t r;
		r = '0;
		r.value = t;
		return r;
	endfunction

	function automatic dir_row_t pinned_row(logic [TAG_W-1:0] t, logic signed [PWR_W-1:0] pw,
		logic [IDX_W-1:0] st);
		dir_row_t r;
		r = item_row(t);
		r.pinned = 1'b1;
		r.power = pw;
		r.step = st;
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_tag(logic [TAG_W-1:0] t);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= t;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (power_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] a, logic [CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// random register settings, with junk in unused upper bits now and then
	task automatic shuffle_config();
		logic [CFG_DATA_W-1:0] v;
		int a;
		for (a = 0; a <= int'(REG_SPARE); a++) begin
			if ($urandom_range(0, (a == int'(REG_SPARE)) ? 7 : 1) != 0) continue;
			v = CFG_DATA_W'($urandom_range(0, 65535));
			case (a)
				REG_LOW, REG_HIGH: begin
					case ($urandom_range(0, 3))
						0: v = 16'h8000;
						1: v = 16'h7FFF;
						2: v = CFG_DATA_W'($urandom_range(16'h0A00, 16'h1C00));
						default: ;
					endcase
				end
				REG_PULSE, REG_STEPS: begin
					case ($urandom_range(0, 7))
						0: v = 16'd0;
						1: v = 16'd255;
						2: ;
						default: v = CFG_DATA_W'($urandom_range(1, 8));
					endcase
				end
				default: ;
			endcase
			write_reg(CFG_IDX_W'(a), v);
		end
	endtask

	initial begin : stim
		dir_row_t rows [$];
		int p;
		int k;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		reset_model();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		rows = '{
			pinned_row(16'h0000, 16'sd3840, 4'd0),
			pinned_row(16'hFFFF, 16'sd3840, 4'd0),
			cfg_row(REG_PULSE, 16'd1),
			pinned_row(16'h5555, 16'sd6400, 4'd1),
			pinned_row(16'hAAAA, 16'sd3840, 4'd0),
			cfg_row(REG_LOW, 16'h8000),
			cfg_row(REG_HIGH, 16'h7FFF),
			pinned_row(16'h0001, 16'sh7FFF, 4'd1),
			pinned_row(16'h8000, 16'sh8000, 4'd0),
			cfg_row(REG_PATTERN, 16'(PAT_STAIR4)),
			item_row(16'h1234),
			item_row(16'h4321),
			cfg_row(REG_PATTERN, 16'(PAT_STAIR8)),
			item_row(16'h0F0F),
			item_row(16'hF0F0),
			cfg_row(REG_PATTERN, 16'(PAT_SAW_UP)),
			item_row(16'h0002),
			item_row(16'h0004),
			item_row(16'h0008),
			cfg_row(REG_PATTERN, 16'(PAT_SAW_DN)),
			item_row(16'h0010),
			item_row(16'h0020),
			item_row(16'h0040),
			// write outside the register list: counter keeps running
			cfg_row(REG_SPARE, 16'h1234),
			item_row(16'h0080),
			cfg_row(REG_PATTERN, 16'(PAT_RAMP)),
			cfg_row(REG_STEPS, 16'd0),
			pinned_row(16'h0100, 16'sh7FFF, 4'd0),
			pinned_row(16'h0200, 16'sh8000, 4'd0),
			cfg_row(REG_REVERSE, 16'd1),
			pinned_row(16'h0400, 16'sh8000, 4'd0),
			cfg_row(REG_STEPS, 16'd255),
			cfg_row(REG_OFFSET, 16'd4095),
			item_row(16'h0800),
			cfg_row(REG_PATTERN, 16'(PAT_SPARE)),
			cfg_row(REG_PULSE, 16'd0),
			item_row(16'h1000),
			// high below low
			cfg_row(REG_LOW, 16'h7FFF),
			cfg_row(REG_HIGH, 16'h8000),
			item_row(16'h2000),
			item_row(16'h4000),
			cfg_row(REG_PULSE, 16'd255),
			cfg_row(REG_PATTERN, 16'(PAT_SAW_UP)),
			item_row(16'h7FFF),
			item_row(16'hFFFE)
		};

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				drain();
				write_reg(rows[i].addr, rows[i].value);
			end else begin
				if (rows[i].pinned) begin
					pin_on = 1'b1;
					pin_power = rows[i].power;
					pin_step = rows[i].step;
				end
				send_tag(rows[i].value);
			end
		end

		for (p = 0; p < N_PHASES; p++) begin
			drain();
			idle_on = (p < N_PHASES - 4);
			if (p > 0) shuffle_config();
			if (p == 8) hold_now = 1'b1;
			for (k = 0; k < PHASE_ITEMS; k++) send_tag(TAG_W'($urandom_range(0, 65535)));
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("[table_pattern_power_generator_top] OK");
		end else begin
			$display("[table_pattern_power_generator_top] ERROR");
		end
		$finish;
	end

endmodule

// ===== table_pattern_power_generator_top.f =====
design/tpg_pkg.sv
design/tpg_arith.sv
design/table_pattern_power_generator_top.sv
dv/tb.sv
